// File: src/fat_chain_engine_core_macros.svh
// Assertion macros shared by the fat chain engine RTL.
// Depends on nothing; files that assert include it by name.
`ifndef FAT_CHAIN_ENGINE_CORE_MACROS_SVH
`define FAT_CHAIN_ENGINE_CORE_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define FCE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define FCE_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// File: src/fce_pkg.sv
// Package of the fat chain engine: constants, operation and status codes.
// Used by the top level.
package fce_pkg;

   localparam int TABLE_DEPTH_DEF = 8192;
   localparam int NW = 17;
   localparam logic [15:0] CHAIN_END = 16'hFFFF;
   localparam logic [13:0] COUNT_RESET = 14'd8192;
   localparam logic [15:0] START_RESET = 16'd6;
   localparam logic [12:0] FREE_MAX = 13'h1FFF;

   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_READ = 3'd1;
   localparam logic [2:0] OP_LOCATE = 3'd2;
   localparam logic [2:0] OP_EXTEND = 3'd3;
   localparam logic [2:0] OP_FREE = 3'd4;
   localparam logic [2:0] OP_COUNT = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_PAST_END = 2'd2;
   localparam logic [1:0] ST_BROKEN = 2'd3;

   localparam logic CSR_COUNT = 1'b0;
   localparam logic CSR_START = 1'b1;

endpackage

// File: src/fce_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing but its parameters.
module fce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/fat_chain_engine_core.sv
// Fat chain engine top level: command sequencer around the allocation table RAM.
// Depends on fce_pkg, fce_ram and fat_chain_engine_core_macros.svh.
// After reset a clearing pass writes every table entry before the first word is taken.
// Requests are taken one word at a time, and only in the idle state.
// Locate, extend and free walk the chain link by link through the single read port.
// Extend scans one entry per cycle per new block, then marks it chain end and links it in.
module fat_chain_engine_core #(
   parameter int TABLE_DEPTH = fce_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index, entry_value, chain_head, chain_len, from bit 0 up.
   input  logic [63:0] req_tdata,
   // op.
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value, new_head, found_entry, disk_blk, free_count, from bit 0 up.
   output logic [79:0] rsp_tdata,
   // status.
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fce_pkg::*;
   `include "fat_chain_engine_core_macros.svh"

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD_WAIT = 4'd2;
   localparam logic [3:0] S_WALK_ISSUE = 4'd3;
   localparam logic [3:0] S_WALK_EVAL = 4'd4;
   localparam logic [3:0] S_EXT_CHECK = 4'd5;
   localparam logic [3:0] S_SCAN = 4'd6;
   localparam logic [3:0] S_ALLOC = 4'd7;
   localparam logic [3:0] S_ALLOC_LINK = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [13:0]   blk_count_ff, blk_count_in;
   logic [15:0]   blk_start_ff, blk_start_in;
   logic [2:0]    op_ff, op_in;
   logic [12:0]   idx_ff, idx_in;
   logic [13:0]   bc_ff, bc_in;
   logic [15:0]   cur_ff, cur_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] paddr_ff, paddr_in;
   logic [AW-1:0] pick_ff, pick_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [1:0]    status_ff, status_in;
   logic [15:0]   rdv_ff, rdv_in;
   logic [15:0]   nh_ff, nh_in;
   logic [12:0]   found_ff, found_in;
   logic [15:0]   disk_ff, disk_in;
   logic [12:0]   freec_ff, freec_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [79:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata, mem_rdata;

   logic [NW-1:0] n_w;
   logic [NW-1:0] n_m1;
   logic          out_free;
   logic          csr_wr;
   logic [12:0]   in_idx;
   logic [15:0]   in_val, in_head, nx;
   logic [13:0]   in_bc;
   logic          in_idx_ok, idx_ok, head_ok, nx_ok, hit;

   function automatic logic link_ok(input logic [15:0] v, input logic [NW-1:0] n);
      link_ok = (v != 16'd0) && (NW'(v) < n);
   endfunction

   fce_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign n_w = (NW'(blk_count_ff) > DEPTH_N) ? DEPTH_N : NW'(blk_count_ff);
   assign n_m1 = n_w - NW'(1);
   assign in_idx = req_tdata[12:0];
   assign in_val = req_tdata[28:13];
   assign in_head = req_tdata[44:29];
   assign in_bc = req_tdata[58:45];
   assign in_idx_ok = NW'(in_idx) < DEPTH_N;
   assign idx_ok = NW'(idx_ff) < DEPTH_N;
   assign head_ok = link_ok(in_head, n_w);
   assign nx = mem_rdata;
   assign nx_ok = link_ok(nx, n_w);
   assign hit = pend_ff && (mem_rdata == 16'd0);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_START) ? {16'd0, blk_start_ff} :
                                                     {18'd0, blk_count_ff};

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      blk_count_in = blk_count_ff;
      blk_start_in = blk_start_ff;
      op_in = op_ff;
      idx_in = idx_ff;
      bc_in = bc_ff;
      cur_in = cur_ff;
      cnt_in = cnt_ff;
      ptr_in = ptr_ff;
      pend_in = 1'b0;
      paddr_in = paddr_ff;
      pick_in = pick_ff;
      tail_in = tail_ff;
      status_in = status_ff;
      rdv_in = rdv_ff;
      nh_in = nh_ff;
      found_in = found_ff;
      disk_in = disk_ff;
      freec_in = freec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = 16'd0;
      mem_re = 1'b0;
      mem_raddr = '0;

      if (csr_wr) begin
         if (csr_paddr[2] == CSR_COUNT) begin
            blk_count_in = csr_pwdata[13:0];
         end else begin
            blk_start_in = csr_pwdata[15:0];
         end
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff == '0) ? CHAIN_END : 16'd0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               idx_in = in_idx;
               bc_in = in_bc;
               cur_in = in_head;
               cnt_in = '0;
               ptr_in = NW'(1);
               status_in = ST_OK;
               rdv_in = 16'd0;
               nh_in = 16'd0;
               found_in = 13'd0;
               disk_in = 16'd0;
               freec_in = 13'd0;
               state_in = S_DONE;
               case (req_tuser)
                  OP_LOAD: begin
                     mem_we = in_idx_ok;
                     mem_waddr = AW'(in_idx);
                     mem_wdata = in_val;
                  end
                  OP_READ: begin
                     mem_re = 1'b1;
                     mem_raddr = AW'(in_idx);
                     state_in = S_RD_WAIT;
                  end
                  OP_LOCATE: begin
                     if (in_head == CHAIN_END) begin
                        status_in = ST_PAST_END;
                     end else if (!head_ok) begin
                        status_in = ST_BROKEN;
                     end else begin
                        state_in = S_WALK_ISSUE;
                     end
                  end
                  OP_EXTEND: begin
                     nh_in = in_head;
                     if (in_head == CHAIN_END) begin
                        state_in = S_EXT_CHECK;
                     end else if (!head_ok) begin
                        status_in = ST_BROKEN;
                     end else begin
                        cnt_in = NW'(1);
                        state_in = S_WALK_ISSUE;
                     end
                  end
                  OP_FREE: begin
                     nh_in = CHAIN_END;
                     if (in_head != CHAIN_END) begin
                        if (!head_ok) begin
                           status_in = ST_BROKEN;
                        end else begin
                           state_in = S_WALK_ISSUE;
                        end
                     end
                  end
                  OP_COUNT: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            rdv_in = idx_ok ? mem_rdata : 16'd0;
            state_in = S_DONE;
         end
         S_WALK_ISSUE: begin
            if (op_ff == OP_LOCATE && cnt_ff >= NW'(bc_ff)) begin
               found_in = cur_ff[12:0];
               disk_in = blk_start_ff + cur_ff;
               state_in = S_DONE;
            end else begin
               mem_re = 1'b1;
               mem_raddr = cur_ff[AW-1:0];
               state_in = S_WALK_EVAL;
            end
         end
         S_WALK_EVAL: begin
            state_in = S_WALK_ISSUE;
            case (op_ff)
               OP_LOCATE: begin
                  if (nx == CHAIN_END) begin
                     status_in = ST_PAST_END;
                     state_in = S_DONE;
                  end else if (!nx_ok || (cnt_ff + NW'(1) >= n_m1)) begin
                     status_in = ST_BROKEN;
                     state_in = S_DONE;
                  end else begin
                     cur_in = nx;
                     cnt_in = cnt_ff + NW'(1);
                  end
               end
               OP_EXTEND: begin
                  if (nx == CHAIN_END) begin
                     tail_in = cur_ff[AW-1:0];
                     state_in = S_EXT_CHECK;
                  end else if (!nx_ok || (cnt_ff >= n_m1)) begin
                     status_in = ST_BROKEN;
                     state_in = S_DONE;
                  end else begin
                     cur_in = nx;
                     cnt_in = cnt_ff + NW'(1);
                  end
               end
               default: begin
                  mem_we = 1'b1;
                  mem_waddr = cur_ff[AW-1:0];
                  mem_wdata = 16'd0;
                  if (nx == CHAIN_END) begin
                     state_in = S_DONE;
                  end else if (!nx_ok) begin
                     status_in = ST_BROKEN;
                     state_in = S_DONE;
                  end else begin
                     cur_in = nx;
                  end
               end
            endcase
         end
         S_EXT_CHECK: begin
            state_in = (cnt_ff >= NW'(bc_ff)) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            if (op_ff == OP_EXTEND && hit) begin
               pick_in = paddr_ff;
               state_in = S_ALLOC;
            end else begin
               if (op_ff == OP_COUNT && hit && freec_ff != FREE_MAX) begin
                  freec_in = freec_ff + 13'd1;
               end
               if (ptr_ff < n_w) begin
                  mem_re = 1'b1;
                  mem_raddr = ptr_ff[AW-1:0];
                  pend_in = 1'b1;
                  paddr_in = ptr_ff[AW-1:0];
                  ptr_in = ptr_ff + NW'(1);
               end else if (!pend_ff) begin
                  if (op_ff == OP_EXTEND) begin
                     status_in = ST_NO_SPACE;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_ALLOC: begin
            mem_we = 1'b1;
            mem_waddr = pick_ff;
            mem_wdata = CHAIN_END;
            cnt_in = cnt_ff + NW'(1);
            ptr_in = NW'(pick_ff) + NW'(1);
            if (nh_ff == CHAIN_END) begin
               nh_in = 16'(pick_ff);
               tail_in = pick_ff;
               state_in = S_EXT_CHECK;
            end else begin
               state_in = S_ALLOC_LINK;
            end
         end
         S_ALLOC_LINK: begin
            mem_we = 1'b1;
            mem_waddr = tail_ff;
            mem_wdata = 16'(pick_ff);
            tail_in = pick_ff;
            state_in = S_EXT_CHECK;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = status_ff;
               rsp_data_in = {6'd0, freec_ff, disk_ff, found_ff, nh_ff, rdv_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blk_count_ff <= COUNT_RESET;
         blk_start_ff <= START_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         blk_count_ff <= blk_count_in;
         blk_start_ff <= blk_start_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      idx_ff <= idx_in;
      bc_ff <= bc_in;
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      ptr_ff <= ptr_in;
      paddr_ff <= paddr_in;
      pick_ff <= pick_in;
      tail_ff <= tail_in;
      status_ff <= status_in;
      rdv_ff <= rdv_in;
      nh_ff <= nh_in;
      found_ff <= found_in;
      disk_ff <= disk_in;
      freec_ff <= freec_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `FCE_ASSERT(a_idle_no_write, (state_ff == S_IDLE && !req_tvalid) |-> !mem_we, "idle write")
   `FCE_NEVER(a_clear_blocks, (state_ff == S_CLEAR) && req_tready, "accept during clear")
   `FCE_ASSERT(a_walk_bound, (state_ff == S_WALK_EVAL) |-> (cnt_ff < n_w), "walk overrun")
   `FCE_ASSERT(a_done_delivers, (state_ff == S_DONE && out_free) |=> rsp_valid_ff, "lost word")
endmodule
